// File: sv/smx_pkg.sv
// shared constants, tables and types for the softmax vector block
package smx_pkg;
	localparam int MaxClasses = 64;
	localparam int AddrW = $clog2(MaxClasses);
	localparam int CountW = 7;
	localparam int ScoreW = 16;
	localparam int ExpW = 16;
	localparam int SumW = 22;
	localparam int QuotW = 16;
	localparam logic [15:0] CutoffQ88 = 16'd12800;

	typedef struct packed {
		logic [QuotW-1:0] probability;
		logic [5:0] class_index;
		logic last;
	} result_t;

	typedef struct packed {
		logic start;
		logic [SumW-1:0] divisor;
		logic [ExpW-1:0] dividend;
	} div_req_t;

	function automatic logic [15:0] exp_int(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0: r = 16'd32768;
			4'd1: r = 16'd12055;
			4'd2: r = 16'd4435;
			4'd3: r = 16'd1631;
			4'd4: r = 16'd600;
			4'd5: r = 16'd221;
			4'd6: r = 16'd81;
			4'd7: r = 16'd30;
			4'd8: r = 16'd11;
			4'd9: r = 16'd4;
			4'd10: r = 16'd1;
			4'd11: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] exp_hi(input logic [3:0] h);
		logic [15:0] r;
		case (h)
			4'd0: r = 16'd32768;
			4'd1: r = 16'd30783;
			4'd2: r = 16'd28918;
			4'd3: r = 16'd27166;
			4'd4: r = 16'd25520;
			4'd5: r = 16'd23974;
			4'd6: r = 16'd22521;
			4'd7: r = 16'd21157;
			4'd8: r = 16'd19875;
			4'd9: r = 16'd18671;
			4'd10: r = 16'd17539;
			4'd11: r = 16'd16477;
			4'd12: r = 16'd15479;
			4'd13: r = 16'd14541;
			4'd14: r = 16'd13660;
			default: r = 16'd12832;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] exp_lo(input logic [3:0] l);
		logic [15:0] r;
		case (l)
			4'd0: r = 16'd32768;
			4'd1: r = 16'd32640;
			4'd2: r = 16'd32513;
			4'd3: r = 16'd32386;
			4'd4: r = 16'd32260;
			4'd5: r = 16'd32134;
			4'd6: r = 16'd32009;
			4'd7: r = 16'd31884;
			4'd8: r = 16'd31760;
			4'd9: r = 16'd31636;
			4'd10: r = 16'd31513;
			4'd11: r = 16'd31390;
			4'd12: r = 16'd31267;
			4'd13: r = 16'd31146;
			4'd14: r = 16'd31024;
			default: r = 16'd30903;
		endcase
		return r;
	endfunction
endpackage

// File: sv/smx_if.sv
// valid/ready channel interfaces for scores and results
interface smx_score_if;
	logic valid;
	logic ready;
	logic [smx_pkg::ScoreW-1:0] score;
	modport source (output valid, output score, input ready);
	modport sink (input valid, input score, output ready);
endinterface

interface smx_result_if;
	logic valid;
	logic ready;
	logic [smx_pkg::QuotW-1:0] probability;
	logic [5:0] class_index;
	logic last;
	modport source (output valid, output probability, output class_index, output last,
		input ready);
	modport sink (input valid, input probability, input class_index, input last,
		output ready);
endinterface

// File: sv/smx_ram.sv
// generic single-port-write ram with registered read
module smx_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/smx_exp.sv
// two-stage fixed point exp(-m) from three tables
module smx_exp (
	input  logic        clk,
	input  logic [15:0] diff,
	output logic [15:0] expv
);
	logic [15:0] t_s1;
	logic [3:0]  l_s1;
	logic        zero_s1;
	logic [31:0] p1;
	logic [31:0] p2;
	logic [3:0]  ii;

	always_comb begin
		ii = (diff[15:8] >= 8'd12) ? 4'd12 : diff[11:8];
		p1 = 32'(smx_pkg::exp_int(ii)) * 32'(smx_pkg::exp_hi(diff[7:4])) + 32'd16384;
	end

	always_ff @(posedge clk) begin
		t_s1 <= p1[30:15];
		l_s1 <= diff[3:0];
		zero_s1 <= (diff >= smx_pkg::CutoffQ88);
	end

	always_comb begin
		p2 = 32'(t_s1) * 32'(smx_pkg::exp_lo(l_s1)) + 32'd16384;
		expv = zero_s1 ? 16'd0 : p2[30:15];
	end
endmodule

// File: sv/smx_div.sv
// restoring divider, one quotient bit per cycle: dividend*32768 / divisor
module smx_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  smx_pkg::div_req_t            req,
	output logic                         done,
	output logic [smx_pkg::QuotW-1:0]    quot
);
	localparam int NumW = smx_pkg::ExpW + 15;
	logic [NumW-1:0]          num_q;
	logic [smx_pkg::SumW:0]   rem_q;
	logic [smx_pkg::SumW-1:0] dsr_q;
	logic [4:0]               cnt_q;
	logic                     busy_q;
	logic [smx_pkg::SumW:0]   trial;

	assign trial = {rem_q[smx_pkg::SumW-1:0], num_q[NumW-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(NumW - 1);
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {req.dividend, 15'd0};
			rem_q <= '0;
			dsr_q <= req.divisor;
			quot <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!trial[smx_pkg::SumW]) begin
				rem_q <= trial;
				quot <= {quot[smx_pkg::QuotW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[smx_pkg::SumW-1:0], num_q[NumW-1]};
				quot <= {quot[smx_pkg::QuotW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: sv/softmax_vector.sv
// softmax vector top level: load, exp-sum pass, exp-divide pass
// throughput: one score per cycle while loading; results one at a time, each after its own exp read and divide
// exp is computed twice per entry (sum pass and output pass) from one score ram
// reset: asynchronous active low, class_count 10, vector empty; ram needs no clear
module softmax_vector (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [smx_pkg::CountW-1:0] cfg_wdata,
	smx_score_if.sink in_ch,
	smx_result_if.source out_ch
);
	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_SUM   = 6'b000010,
		ST_RD    = 6'b000100,
		ST_EXP   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam int AW = smx_pkg::AddrW;
	localparam int CW = smx_pkg::CountW;

	state_t state_q;
	logic [CW-1:0] class_count_q;
	logic [CW-1:0] loaded_q;
	logic signed [15:0] max_q;
	logic [smx_pkg::SumW-1:0] sum_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] k_q;
	logic [2:0] pipe_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] eff;
	logic [CW-1:0] next_loaded;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [15:0] rdata;
	logic [15:0] diff;
	logic [15:0] expv;
	logic accept;
	logic res_load;
	logic div_done;
	logic [smx_pkg::QuotW-1:0] quot;
	smx_pkg::div_req_t dreq;
	smx_pkg::result_t res_q;
	logic res_valid_q;

	always_comb begin
		if (class_count_q == '0) eff = CW'(1);
		else if (class_count_q > CW'(smx_pkg::MaxClasses)) eff = CW'(smx_pkg::MaxClasses);
		else eff = class_count_q;
		waddr = (loaded_q >= CW'(smx_pkg::MaxClasses)) ? AW'(smx_pkg::MaxClasses - 1)
			: loaded_q[AW-1:0];
		next_loaded = CW'(waddr) + CW'(1);
	end

	assign in_ch.ready = (state_q == ST_LOAD);
	assign accept = in_ch.valid && in_ch.ready;
	assign res_load = (state_q == ST_OUT) && (!res_valid_q || out_ch.ready);
	assign raddr = rd_q[AW-1:0];
	assign diff = 16'(max_q - $signed(rdata));

	smx_ram #(.Width(16), .Depth(smx_pkg::MaxClasses)) u_ram (
		.clk(clk), .we(accept), .waddr(waddr), .wdata(in_ch.score),
		.raddr(raddr), .rdata(rdata)
	);

	smx_exp u_exp (.clk(clk), .diff(diff), .expv(expv));

	always_comb begin
		dreq.start = (state_q == ST_EXP) && pipe_q[2];
		dreq.divisor = sum_q;
		dreq.dividend = expv;
	end

	smx_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .quot(quot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			class_count_q <= CW'(10);
			loaded_q <= '0;
			max_q <= 16'sh8000;
			sum_q <= '0;
			rd_q <= '0;
			k_q <= '0;
			n_q <= '0;
			pipe_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) class_count_q <= cfg_wdata;
			if (res_load) res_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if ($signed(in_ch.score) > max_q) max_q <= $signed(in_ch.score);
						if (next_loaded >= eff) begin
							loaded_q <= '0;
							n_q <= next_loaded;
							sum_q <= '0;
							rd_q <= '0;
							pipe_q <= '0;
							state_q <= ST_SUM;
						end else begin
							loaded_q <= next_loaded;
						end
					end
				end
				ST_SUM: begin
					// read address issues each cycle; exp result follows through the ram read register and the exp stage register
					if (pipe_q[1]) sum_q <= sum_q + smx_pkg::SumW'(expv);
					if (rd_q >= n_q && pipe_q == 3'b100) begin
						rd_q <= '0;
						k_q <= '0;
						pipe_q <= '0;
						state_q <= ST_RD;
					end else begin
						pipe_q <= {pipe_q[1:0], rd_q < n_q};
						if (rd_q < n_q) rd_q <= rd_q + CW'(1);
					end
				end
				ST_RD: begin
					pipe_q <= 3'b001;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					pipe_q <= {pipe_q[1:0], 1'b0};
					if (pipe_q[2]) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load) begin
						if (k_q + CW'(1) >= n_q) begin
							max_q <= 16'sh8000;
							state_q <= ST_LOAD;
						end else begin
							rd_q <= k_q + CW'(1);
							state_q <= ST_RD;
						end
						k_q <= k_q + CW'(1);
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.probability <= quot;
			res_q.class_index <= k_q[AW-1:0];
			res_q.last <= (k_q + CW'(1) >= n_q);
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.probability = res_q.probability;
	assign out_ch.class_index = 6'(res_q.class_index);
	assign out_ch.last = res_q.last;
endmodule
